[rtl/wida_pkg.sv]
// ----------------------------------------------------------------------------
// wida_pkg
// Shared types and constants for the weighted I-divergence accumulator.
// ----------------------------------------------------------------------------
package wida_pkg;

	localparam int OP_W   = 32;               // multiplier operand width
	localparam int PROD_W = 2 * OP_W;         // multiplier product width
	localparam int SUM_W  = 64;               // term and running sum width

	// ln(2) with 28 fraction bits
	localparam logic [OP_W-1:0] LN2_Q28 = 32'd186065280;

	typedef logic [1:0] status_t;

	localparam status_t STATUS_OK         = 2'd0;
	localparam status_t STATUS_ZERO_PARAM = 2'd1;
	localparam status_t STATUS_SAT        = 2'd2;

	// one finished item handed from the term engine to the accumulator
	typedef struct packed {
		logic             last;
		logic             zero_param;
		logic             term_sat;
		logic [SUM_W-1:0] term;
	} wida_res_t;

endpackage

[rtl/wida_mul.sv]
// ----------------------------------------------------------------------------
// wida_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module wida_mul
	import wida_pkg::*;
(
	input  logic              clk,
	input  logic [OP_W-1:0]   a,
	input  logic [OP_W-1:0]   b,
	output logic [PROD_W-1:0] prod_q
);

	logic [PROD_W-1:0] prod;

	assign prod = PROD_W'(a) * PROD_W'(b);

	always_ff @(posedge clk) begin
		prod_q <= prod;
	end

endmodule

[rtl/wida_core.sv]
// ----------------------------------------------------------------------------
// wida_core
// Term engine: sequencer around the shared multiplier that forms
// w*(c*v - x*ln(v)) for one item, rounded and clamped to 64 bits.
// ----------------------------------------------------------------------------
module wida_core
	import wida_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [31:0]     weight,
	input  logic [31:0]     centroid_value,
	input  logic [31:0]     data_value,
	input  logic [31:0]     cluster_param,
	input  logic            last_column,
	output logic            busy,
	output logic            res_valid,
	output wida_res_t       res,
	input  logic            res_take
);

	localparam int LN_SH = 58 - FRAC_BITS;
	localparam logic [5:0] FB6 = 6'(FRAC_BITS);
	localparam logic [95:0] HALF = 96'(1) << (FRAC_BITS - 1);
	localparam logic [4:0] NORM_LAST = 5'd4;
	localparam logic [4:0] SQ_LAST = 5'd29;

	typedef enum logic [4:0] {
		S_IDLE, S_NORM, S_SQ_MUL, S_SQ_UPD, S_LOG_MAG,
		S_LN_LO, S_LN_HI, S_LN_SUM, S_LN_RND,
		S_DL_MUL, S_DL_RND, S_DIFF,
		S_W_LO, S_W_HI, S_W_SUM, S_CLAMP, S_NEG, S_FIN
	} state_t;

	state_t            state_q;
	logic [31:0]       wgt_q, cen_q, dat_q, par_q;
	logic              last_q, zp_q, tsat_q;
	logic [31:0]       sq_q;
	logic [4:0]        m_q;
	logic [4:0]        cnt_q;
	logic [29:0]       frac_q;
	logic              lneg_q;
	logic [35:0]       l2mag_q;
	logic [95:0]       acc_q;
	logic [31:0]       lmag_q;
	logic [63:0]       cpf_q, dlf_q, a_q, term_q;
	logic              dneg_q;

	logic [OP_W-1:0]   mul_a, mul_b;
	logic [PROD_W-1:0] prod_q;

	logic [4:0]        norm_sh;
	logic              norm_top_zero;
	logic [5:0]        m6, pos_k, neg_k;
	logic              log_pos;
	logic [35:0]       l2mag_next;
	logic [63:0]       ln_shifted;
	logic [31:0]       lmag_next;
	logic [63:0]       cpf_next, dlf_next;
	logic [63:0]       a_next;
	logic              dneg_next;
	logic              hi_ovf, mag_over;
	logic [63:0]       mag_sel;

	wida_mul u_mul (
		.clk    (clk),
		.a      (mul_a),
		.b      (mul_b),
		.prod_q (prod_q)
	);

	always_comb begin
		unique case (state_q)
			S_SQ_MUL: begin
				mul_a = sq_q;
				mul_b = sq_q;
			end
			S_LN_LO: begin
				mul_a = l2mag_q[31:0];
				mul_b = LN2_Q28;
			end
			S_LN_HI: begin
				mul_a = {28'b0, l2mag_q[35:32]};
				mul_b = LN2_Q28;
			end
			S_LN_SUM: begin
				mul_a = cen_q;
				mul_b = par_q;
			end
			S_DL_MUL: begin
				mul_a = dat_q;
				mul_b = lmag_q;
			end
			S_W_LO: begin
				mul_a = a_q[31:0];
				mul_b = wgt_q;
			end
			S_W_HI: begin
				mul_a = a_q[63:32];
				mul_b = wgt_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_comb begin
		// leading-one search: halving shift steps 16, 8, 4, 2, 1
		norm_sh       = 5'd16 >> cnt_q[2:0];
		norm_top_zero = (sq_q >> (6'd32 - {1'b0, norm_sh})) == 32'b0;

		// log2 = (msb - FRAC_BITS) + frac, kept as sign and magnitude
		m6      = {1'b0, m_q};
		log_pos = m6 >= FB6;
		pos_k   = m6 - FB6;
		neg_k   = FB6 - m6;
		if (log_pos) begin
			l2mag_next = {1'b0, pos_k[4:0], frac_q};
		end else begin
			l2mag_next = {neg_k, 30'b0} - {6'b0, frac_q};
		end

		// round half away from zero on magnitudes
		ln_shifted = acc_q[63:0] >> LN_SH;
		lmag_next  = ln_shifted[31:0] + {31'b0, acc_q[LN_SH-1]};
		cpf_next   = (prod_q >> FRAC_BITS) + {63'b0, prod_q[FRAC_BITS-1]};
		dlf_next   = (prod_q >> FRAC_BITS) + {63'b0, prod_q[FRAC_BITS-1]};

		if (lneg_q) begin
			a_next    = cpf_q + dlf_q;
			dneg_next = 1'b0;
		end else if (dlf_q > cpf_q) begin
			a_next    = dlf_q - cpf_q;
			dneg_next = 1'b1;
		end else begin
			a_next    = cpf_q - dlf_q;
			dneg_next = 1'b0;
		end

		hi_ovf   = |acc_q[95:64+FRAC_BITS];
		mag_sel  = acc_q[63+FRAC_BITS:FRAC_BITS];
		mag_over = dneg_q ? (mag_sel[63] & (|mag_sel[62:0])) : mag_sel[63];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			wgt_q   <= '0;
			cen_q   <= '0;
			dat_q   <= '0;
			par_q   <= '0;
			last_q  <= 1'b0;
			zp_q    <= 1'b0;
			tsat_q  <= 1'b0;
			sq_q    <= '0;
			m_q     <= '0;
			cnt_q   <= '0;
			frac_q  <= '0;
			lneg_q  <= 1'b0;
			l2mag_q <= '0;
			acc_q   <= '0;
			lmag_q  <= '0;
			cpf_q   <= '0;
			dlf_q   <= '0;
			a_q     <= '0;
			dneg_q  <= 1'b0;
			term_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						wgt_q  <= weight;
						cen_q  <= centroid_value;
						dat_q  <= data_value;
						par_q  <= cluster_param;
						last_q <= last_column;
						sq_q   <= cluster_param;
						m_q    <= 5'd31;
						cnt_q  <= '0;
						frac_q <= '0;
						term_q <= '0;
						tsat_q <= 1'b0;
						zp_q   <= (weight != 32'b0) && (cluster_param == 32'b0);
						if (weight == 32'b0 || cluster_param == 32'b0) begin
							state_q <= S_FIN;
						end else begin
							state_q <= S_NORM;
						end
					end
				end
				S_NORM: begin
					if (norm_top_zero) begin
						sq_q <= sq_q << norm_sh;
						m_q  <= m_q - norm_sh;
					end
					if (cnt_q == NORM_LAST) begin
						cnt_q   <= '0;
						state_q <= S_SQ_MUL;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				S_SQ_MUL: begin
					state_q <= S_SQ_UPD;
				end
				S_SQ_UPD: begin
					// square is in [1,4): renormalize to [1,2) and emit one bit
					if (prod_q[63]) begin
						sq_q <= prod_q[63:32];
					end else begin
						sq_q <= prod_q[62:31];
					end
					frac_q <= {frac_q[28:0], prod_q[63]};
					if (cnt_q == SQ_LAST) begin
						cnt_q   <= '0;
						state_q <= S_LOG_MAG;
					end else begin
						cnt_q   <= cnt_q + 5'd1;
						state_q <= S_SQ_MUL;
					end
				end
				S_LOG_MAG: begin
					l2mag_q <= l2mag_next;
					lneg_q  <= !log_pos;
					state_q <= S_LN_LO;
				end
				S_LN_LO: begin
					state_q <= S_LN_HI;
				end
				S_LN_HI: begin
					acc_q   <= {32'b0, prod_q};
					state_q <= S_LN_SUM;
				end
				S_LN_SUM: begin
					acc_q   <= {32'b0, acc_q[63:0] + {prod_q[31:0], 32'b0}};
					state_q <= S_LN_RND;
				end
				S_LN_RND: begin
					lmag_q  <= lmag_next;
					cpf_q   <= cpf_next;
					state_q <= S_DL_MUL;
				end
				S_DL_MUL: begin
					state_q <= S_DL_RND;
				end
				S_DL_RND: begin
					dlf_q   <= dlf_next;
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					a_q     <= a_next;
					dneg_q  <= dneg_next;
					state_q <= S_W_LO;
				end
				S_W_LO: begin
					state_q <= S_W_HI;
				end
				S_W_HI: begin
					acc_q   <= {32'b0, prod_q} + HALF;
					state_q <= S_W_SUM;
				end
				S_W_SUM: begin
					acc_q   <= acc_q + {prod_q, 32'b0};
					state_q <= S_CLAMP;
				end
				S_CLAMP: begin
					if (hi_ovf || mag_over) begin
						term_q <= dneg_q ? {1'b1, 63'b0} : {1'b0, {63{1'b1}}};
						tsat_q <= 1'b1;
					end else begin
						term_q <= mag_sel;
					end
					state_q <= S_NEG;
				end
				S_NEG: begin
					// negating the clamped magnitude 2^63 wraps to the minimum
					if (dneg_q) begin
						term_q <= 64'b0 - term_q;
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy      = state_q != S_IDLE;
	assign res_valid = state_q == S_FIN;
	assign res       = '{last: last_q, zero_param: zp_q, term_sat: tsat_q, term: term_q};

endmodule

[rtl/weighted_i_divergence_accumulate.sv]
// ----------------------------------------------------------------------------
// weighted_i_divergence_accumulate
// Accumulates weighted generalized I-divergence terms over one row and
// cluster and emits the saturated sum with a status code on the last column.
// ----------------------------------------------------------------------------
// One item is in work at a time. An item with nonzero weight and nonzero
// parameter holds in_stall high after its transfer until its term is
// handed over; that time is set by the natural log, which runs
// a five-step leading-one search and then 30 squarings, each a multiply and
// a renormalize step through the single shared 32x32 multiplier, followed by
// six more multiplier passes for the scaling, the products and the weight.
// An item with zero weight or zero parameter goes straight to the finish
// state. A last-column item may wait in the engine while an earlier result
// sits stalled in the output register; other items are folded in at once.
// ----------------------------------------------------------------------------
module weighted_i_divergence_accumulate
	import wida_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [31:0]             weight,
	input  logic [31:0]             centroid_value,
	input  logic [31:0]             data_value,
	input  logic [31:0]             cluster_param,
	input  logic                    last_column,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [SUM_W-1:0] divergence,
	output logic [1:0]              status
);

	localparam logic [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
	localparam logic [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

	logic             core_busy;
	logic             res_valid;
	logic             res_take;
	wida_res_t        res;

	logic [SUM_W-1:0] sum_q;
	logic             zp_q, sat_q;
	logic             out_valid_q;
	logic [SUM_W-1:0] div_q;
	status_t          status_q;

	logic [SUM_W-1:0] sum_add, sum_new;
	logic             ovf_pos, ovf_neg;
	logic             zp_new, sat_new;
	status_t          status_next;

	wida_core #(
		.FRAC_BITS (FRAC_BITS)
	) u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.weight         (weight),
		.centroid_value (centroid_value),
		.data_value     (data_value),
		.cluster_param  (cluster_param),
		.last_column    (last_column),
		.busy           (core_busy),
		.res_valid      (res_valid),
		.res            (res),
		.res_take       (res_take)
	);

	assign in_stall = core_busy;

	// a last-column result needs the output register free or leaving
	assign res_take = res_valid && (!res.last || !out_valid_q || !out_stall);

	always_comb begin
		sum_add = sum_q + res.term;
		ovf_pos = !sum_q[SUM_W-1] && !res.term[SUM_W-1] && sum_add[SUM_W-1];
		ovf_neg = sum_q[SUM_W-1] && res.term[SUM_W-1] && !sum_add[SUM_W-1];
		if (ovf_pos) begin
			sum_new = SUM_MAX;
		end else if (ovf_neg) begin
			sum_new = SUM_MIN;
		end else begin
			sum_new = sum_add;
		end
		zp_new  = zp_q | res.zero_param;
		sat_new = sat_q | res.term_sat | ovf_pos | ovf_neg;
		priority if (zp_new) begin
			status_next = STATUS_ZERO_PARAM;
		end else if (sat_new) begin
			status_next = STATUS_SAT;
		end else begin
			status_next = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			zp_q        <= 1'b0;
			sat_q       <= 1'b0;
			out_valid_q <= 1'b0;
			div_q       <= '0;
			status_q    <= STATUS_OK;
		end else begin
			if (res_take && res.last) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (res_take) begin
				if (res.last) begin
					div_q       <= sum_new;
					status_q    <= status_next;
					sum_q       <= '0;
					zp_q        <= 1'b0;
					sat_q       <= 1'b0;
				end else begin
					sum_q <= sum_new;
					zp_q  <= zp_new;
					sat_q <= sat_new;
				end
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign divergence = $signed(div_q);
	assign status     = status_q;

	// a result appears only after the engine hands over a last-column item
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_take && res.last))
		else $error("output raised without a last-column handoff");

	// the engine never finishes in the cycle an input transfer lands
	a_no_accept_at_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |-> !res_valid)
		else $error("input transfer while a term is pending");

	// a closed sum restarts from zero with clear flags
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(res_take && res.last) |=> (sum_q == '0 && !zp_q && !sat_q))
		else $error("running sum not cleared after last column");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (status_q == STATUS_OK || status_q == STATUS_ZERO_PARAM ||
			status_q == STATUS_SAT))
		else $error("undefined status code");

endmodule

[test/tb_weighted_i_divergence_accumulate.sv]
// ----------------------------------------------------------------------------
// tb_weighted_i_divergence_accumulate
// Drives column items into the weighted I-divergence accumulator and checks
// every emitted sum and status against a bit-exact fixed-point predictor:
// a directed table first, then a long sum of negative terms,
// then random sums of random length with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_weighted_i_divergence_accumulate;
	import wida_pkg::*;

	localparam int FRAC = 16;
	localparam int NUM_RANDOM = 1280;
	localparam int NEG_RUN = 200;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;
	localparam logic [31:0] MAX_Q = 32'hFFFF_FFFF;
	localparam logic [63:0] SUM_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] SUM_MIN = 64'h8000_0000_0000_0000;

	typedef struct {
		logic [31:0] weight;
		logic [31:0] centroid;
		logic [31:0] data;
		logic [31:0] cparam;
		logic        last;
		logic        fixed_exp;
		logic [63:0] div;
		status_t     st;
	} column_t;

	typedef struct {
		logic signed [63:0] divergence;
		status_t            status;
	} sum_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [31:0] weight = '0;
	logic [31:0] centroid_value = '0;
	logic [31:0] data_value = '0;
	logic [31:0] cluster_param = '0;
	logic        last_column = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic signed [SUM_W-1:0] divergence;
	logic [1:0]  status;

	sum_report_t pending_sums[$];
	int          mismatches = 0;
	int          stall_left = 0;
	logic        quiet = 1'b0;

	// predictor state
	logic [63:0] acc_sum = '0;
	logic        zp_flag = 1'b0;
	logic        sat_flag = 1'b0;

	// weight, centroid, data, param, last, fixed expectation, sum, status
	column_t directed_cols[20] = '{
		'{32'h0, MAX_Q, MAX_Q, 32'h0, 1'b1, 1'b1, 64'h0, STATUS_OK},
		'{ONE_Q, ONE_Q, ONE_Q, 32'h0, 1'b1, 1'b1, 64'h0, STATUS_ZERO_PARAM},
		'{ONE_Q, 32'h0, MAX_Q, ONE_Q, 1'b1, 1'b1, 64'h0, STATUS_OK},
		'{ONE_Q, ONE_Q, ONE_Q, ONE_Q, 1'b1, 1'b1, 64'h1_0000, STATUS_OK},
		'{MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b1, 1'b1, SUM_MAX, STATUS_SAT},
		'{MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b0, 1'b0, 64'h0, STATUS_OK},
		'{MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b1, 1'b1, SUM_MAX, STATUS_SAT},
		'{ONE_Q, ONE_Q, ONE_Q, 32'h0, 1'b0, 1'b0, 64'h0, STATUS_OK},
		'{MAX_Q, MAX_Q, MAX_Q, MAX_Q, 1'b1, 1'b1, SUM_MAX, STATUS_ZERO_PARAM},
		'{32'h1, 32'h1, 32'h1, 32'h1, 1'b1, 1'b0, 64'h0, STATUS_OK},
		'{ONE_Q, 32'h0002_0000, 32'h0003_0000, 32'h8000_0000, 1'b0, 1'b0, 64'h0, STATUS_OK},
		'{32'h8000, 32'h0001_8000, 32'h8000, 32'h8000, 1'b0, 1'b0, 64'h0, STATUS_OK},
		'{MAX_Q, 32'h0, MAX_Q, MAX_Q, 1'b0, 1'b0, 64'h0, STATUS_OK},
		'{32'h0, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 64'h0, STATUS_OK},
		'{MAX_Q, 32'h0, MAX_Q, 32'h0000_FFFF, 1'b1, 1'b0, 64'h0, STATUS_OK},
		'{MAX_Q, 32'h0, MAX_Q, 32'h0001_0001, 1'b1, 1'b0, 64'h0, STATUS_OK},
		'{ONE_Q, ONE_Q, ONE_Q, 32'h0002_0000, 1'b1, 1'b0, 64'h0, STATUS_OK},
		'{32'h8000_0000, 32'h5555_5555, 32'hAAAA_AAAA, 32'h2, 1'b1, 1'b0, 64'h0, STATUS_OK},
		'{MAX_Q, MAX_Q, 32'h0, 32'h1, 1'b0, 1'b0, 64'h0, STATUS_OK},
		'{ONE_Q, 32'h0, 32'h0, 32'h0, 1'b1, 1'b0, 64'h0, STATUS_OK}
	};

	weighted_i_divergence_accumulate #(
		.FRAC_BITS(FRAC)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.weight        (weight),
		.centroid_value(centroid_value),
		.data_value    (data_value),
		.cluster_param (cluster_param),
		.last_column   (last_column),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.divergence    (divergence),
		.status        (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] round_half(input logic [63:0] v, input int sh);
		logic [63:0] q;
		q = v >> sh;
		if (v[sh-1])
			q = q + 64'd1;
		return q;
	endfunction

	// log2 by normalize plus 30 truncated squarings, then scaled by ln 2
	function automatic logic signed [63:0] natural_log_q(input logic [31:0] p);
		int                 m;
		int                 i;
		logic [63:0]        x;
		logic [63:0]        frac;
		logic [63:0]        umag;
		logic [63:0]        lmag;
		logic signed [63:0] l2;
		m = 31;
		while (m > 0 && !p[m])
			m--;
		x = 64'(p) << (31 - m);
		frac = '0;
		for (i = 0; i < 30; i++) begin
			x = (x * x) >> 31;
			if (x >= 64'h1_0000_0000) begin
				x = x >> 1;
				frac[29-i] = 1'b1;
			end
		end
		l2 = longint'(m - FRAC) * (longint'(1) << 30) + longint'(frac);
		umag = (l2 < 0) ? 64'(-l2) : 64'(l2);
		lmag = round_half(umag * 64'(LN2_Q28), 58 - FRAC);
		return (l2 < 0) ? -$signed(lmag) : $signed(lmag);
	endfunction

	function automatic logic signed [63:0] column_term(input logic [31:0] w, c, x, v,
			output logic sat);
		logic signed [63:0] l;
		logic signed [63:0] d;
		logic [63:0]        lmag;
		logic [63:0]        cpf;
		logic [63:0]        dlf;
		logic [63:0]        a;
		logic [63:0]        mag;
		logic [63:0]        lim;
		logic [127:0]       p;
		logic               lneg;
		logic               dneg;
		sat = 1'b0;
		l = natural_log_q(v);
		lneg = l < 0;
		lmag = lneg ? 64'(-l) : 64'(l);
		cpf = round_half(64'(c) * 64'(v), FRAC);
		dlf = round_half(64'(x) * lmag, FRAC);
		d = $signed(cpf) - (lneg ? -$signed(dlf) : $signed(dlf));
		dneg = d < 0;
		a = dneg ? 64'(-d) : 64'(d);
		p = 128'(a) * 128'(w) + (128'(1) << (FRAC - 1));
		lim = dneg ? SUM_MIN : SUM_MAX;
		if ((p >> (64 + FRAC)) != 0) begin
			mag = lim;
			sat = 1'b1;
		end else begin
			mag = 64'(p >> FRAC);
			if (mag > lim) begin
				mag = lim;
				sat = 1'b1;
			end
		end
		return dneg ? -$signed(mag) : $signed(mag);
	endfunction

	task automatic fold_column(input column_t col, output logic emit,
			output sum_report_t rep);
		logic [63:0] t;
		logic [63:0] r;
		logic        tsat;
		if (col.weight != 0) begin
			if (col.cparam == 0) begin
				zp_flag = 1'b1;
			end else begin
				t = column_term(col.weight, col.centroid, col.data, col.cparam, tsat);
				if (tsat)
					sat_flag = 1'b1;
				r = acc_sum + t;
				if (!acc_sum[63] && !t[63] && r[63]) begin
					r = SUM_MAX;
					sat_flag = 1'b1;
				end else if (acc_sum[63] && t[63] && !r[63]) begin
					r = SUM_MIN;
					sat_flag = 1'b1;
				end
				acc_sum = r;
			end
		end
		emit = col.last;
		rep.divergence = acc_sum;
		rep.status = zp_flag ? STATUS_ZERO_PARAM : (sat_flag ? STATUS_SAT : STATUS_OK);
		if (col.last) begin
			acc_sum = '0;
			zp_flag = 1'b0;
			sat_flag = 1'b0;
		end
	endtask

	task automatic send_column(input column_t col);
		int          gap;
		logic        emit;
		sum_report_t rep;
		gap = quiet ? 0 : $urandom_range(0, 6);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		weight <= col.weight;
		centroid_value <= col.centroid;
		data_value <= col.data;
		cluster_param <= col.cparam;
		last_column <= col.last;
		do @(posedge clk); while (in_stall);
		fold_column(col, emit, rep);
		if (emit) begin
			if (col.fixed_exp)
				pending_sums.push_back(sum_report_t'{$signed(col.div), col.st});
			else
				pending_sums.push_back(rep);
		end
	endtask

	function automatic logic [31:0] rand_q();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return MAX_Q;
			2, 3, 4: return $urandom;
			5, 6, 7: return $urandom_range(32'h0000_4000, 32'h0004_0000);
			8: return $urandom_range(1, 255);
			default: return 32'h1 << $urandom_range(0, 31);
		endcase
	endfunction

	// result side: check each transfer, then stall for a random stretch
	always @(posedge clk) begin : result_check
		sum_report_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_sums.size() == 0) begin
					$display("%0t: unexpected result divergence=%0d status=%0d",
						$time, divergence, status);
					mismatches++;
				end else begin
					want = pending_sums.pop_front();
					if (divergence !== want.divergence) begin
						$display("%0t: divergence expected %0d actual %0d",
							$time, want.divergence, divergence);
						mismatches++;
					end
					if (status !== want.status) begin
						$display("%0t: status expected %0d actual %0d",
							$time, want.status, status);
						mismatches++;
					end
				end
				stall_left = quiet ? 0 : $urandom_range(0, 6);
			end
			if (stall_left > 0) begin
				out_stall <= 1'b1;
				stall_left--;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		column_t col;
		int      total;
		int      len;
		int      k;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_cols[i])
			send_column(directed_cols[i]);

		// long sum of large negative terms, items back to back
		quiet <= 1'b1;
		for (k = 0; k < NEG_RUN; k++) begin
			col = '{MAX_Q, 32'h0, MAX_Q - $urandom_range(0, 255),
				MAX_Q - $urandom_range(0, 255), k == NEG_RUN - 1, 1'b0, 64'h0, STATUS_OK};
			send_column(col);
		end
		quiet <= 1'b0;

		total = 0;
		while (total < NUM_RANDOM) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			for (k = 0; k < len; k++) begin
				col.weight = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_q();
				col.centroid = rand_q();
				col.data = rand_q();
				col.cparam = ($urandom_range(0, 15) == 0) ? 32'h0 : rand_q();
				col.last = (k == len - 1);
				col.fixed_exp = 1'b0;
				col.div = '0;
				col.st = STATUS_OK;
				send_column(col);
				total++;
				if (total % 100 == 0)
					quiet <= ($urandom_range(0, 3) == 0);
			end
		end
		in_valid <= 1'b0;

		while (pending_sums.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (mismatches == 0)
			$display("tb_weighted_i_divergence_accumulate OK");
		else
			$display("tb_weighted_i_divergence_accumulate NOT OK");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("tb_weighted_i_divergence_accumulate NOT OK");
		$finish;
	end

endmodule
